### design/packed_pattern_decoder_defines.svh
// ----------------------------------------------------------------------------
// Packed pattern decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_PATTERN_DECODER_DEFINES_SVH
`define PACKED_PATTERN_DECODER_DEFINES_SVH

// Same-cycle implication.
`define PPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppd assertion failed");

// Next-cycle implication.
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppd assertion failed");

`endif

### design/ppd_pkg.sv
// ----------------------------------------------------------------------------
// Packed pattern decoder package
// Result type, effect codes and the byte conversions of the decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int ROWS = 64;

	localparam logic [7:0] NOTE_CUT    = 8'd254;
	localparam logic [7:0] NOTE_MAX_IN = 8'd127;
	localparam logic [7:0] INSTR_MAX   = 8'd99;
	localparam logic [7:0] VOL_MAX     = 8'd64;
	localparam logic [7:0] VOL_EMPTY   = 8'd255;

	localparam logic [7:0] EFF_TEMPO    = 8'd3;
	localparam logic [7:0] EFF_VSLIDE   = 8'd4;
	localparam logic [7:0] EFF_GVOL     = 8'd22;
	localparam logic [7:0] EFF_PAN      = 8'd24;
	localparam logic [7:0] EFF_SPECIAL  = 8'd19;
	localparam logic [7:0] PAN_SURROUND = 8'hA4;
	localparam logic [7:0] SPC_SURROUND = 8'h91;

	typedef struct packed {
		logic [5:0] row;
		logic [4:0] channel;
		logic       note_write;
		logic [7:0] note;
		logic       instr_write;
		logic [6:0] instrument;
		logic       vol_write;
		logic [6:0] volume;
		logic       fx_write;
		logic [7:0] effect;
		logic [7:0] param;
		logic       row_end;
	} res_t;

	// 12 + octave*12 + semitone, octave is 0..7 for bytes up to 127
	function automatic logic [7:0] note_conv(input logic [7:0] b);
		logic [2:0] oct;
		oct = b[6:4];
		return 8'({oct, 3'b000}) + 8'({oct, 2'b00}) + 8'd12 + 8'(b[3:0]);
	endfunction

	function automatic logic [7:0] double_sat(input logic [7:0] p);
		return p[7] ? 8'hFF : {p[6:0], 1'b0};
	endfunction

	// hex-coded tempo to decimal: lo + hi/2 + hi/8 with hi = param & 0xF0
	function automatic logic [7:0] tempo_conv(input logic [7:0] p);
		return 8'(p[3:0]) + 8'({p[7:4], 3'b000}) + 8'({p[7:4], 1'b0});
	endfunction

endpackage

### design/packed_pattern_decoder.sv
// ----------------------------------------------------------------------------
// Packed pattern decoder
// Walks a packed tracker pattern byte by byte and emits cell writes and row ends.
// ----------------------------------------------------------------------------
// Takes one pattern byte per cycle while data_ready is high and emits at most
// one registered result per byte. Each entry opens with a mask
// byte (channel in bits 4:0, bit 5 note+instrument, bit 6 volume, bit 7
// effect+parameter); the cell result appears with the entry's last byte, a
// zero mask gives a row-end result. After 64 rows further bytes are dropped
// until a byte arrives with pattern_start set. The result side is a result
// register backed by a one-entry skid register, so data_ready is low only
// while both entries are full, i.e. once a second result has arrived behind
// one the result side has not yet taken; with result_ready held high the
// block sustains one byte per clock.
`include "packed_pattern_decoder_defines.svh"

module packed_pattern_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       pattern_start,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [5:0] row,
	output logic [4:0] channel,
	output logic       note_write,
	output logic [7:0] note,
	output logic       instr_write,
	output logic [6:0] instrument,
	output logic       vol_write,
	output logic [6:0] volume,
	output logic       fx_write,
	output logic [7:0] effect,
	output logic [7:0] param,
	output logic       row_end
);
	import ppd_pkg::*;

	typedef enum logic [2:0] {
		PH_MASK,
		PH_NOTE,
		PH_INSTR,
		PH_VOL,
		PH_FX,
		PH_PARAM,
		PH_DONE
	} phase_t;

	// parse state
	phase_t     phase_q;
	logic [6:0] row_q;
	logic [7:0] mask_q;
	logic [7:0] note_q;
	logic       note_flag_q;
	logic [6:0] instr_q;
	logic [6:0] vol_q;
	logic       vol_flag_q;
	logic [7:0] fx_q;

	// result register and skid entry
	logic       out_valid_q;
	logic       skid_valid_q;
	res_t       out_q;
	res_t       skid_q;

	// next-state and result, all from the current byte
	phase_t     phase_n;
	phase_t     phase_e;
	logic [6:0] row_e;
	logic [6:0] row_n;
	logic [7:0] mask_n;
	logic [7:0] note_n;
	logic       note_flag_n;
	logic [6:0] instr_n;
	logic [6:0] vol_n;
	logic       vol_flag_n;
	logic [7:0] fx_n;
	logic       has_res;
	logic       cell_done;
	logic       fx_wr;
	logic [7:0] eff;
	logic [7:0] par;
	res_t       res;

	logic       accept;
	logic       take;

	assign data_ready = !skid_valid_q;
	assign accept     = data_valid && data_ready;
	assign take       = out_valid_q && result_ready;

	always_comb begin
		// pattern start restarts the row count and reads this byte as a mask
		phase_e     = pattern_start ? PH_MASK : phase_q;
		row_e       = pattern_start ? 7'd0 : row_q;
		phase_n     = phase_e;
		row_n       = row_e;
		mask_n      = mask_q;
		note_n      = note_q;
		note_flag_n = note_flag_q;
		instr_n     = instr_q;
		vol_n       = vol_q;
		vol_flag_n  = vol_flag_q;
		fx_n        = fx_q;
		has_res     = 1'b0;
		cell_done   = 1'b0;
		fx_wr       = 1'b0;
		eff         = fx_q;
		par         = data_byte;
		res         = '0;

		unique case (phase_e)
			PH_MASK: begin
				if (data_byte == 8'd0) begin
					has_res = 1'b1;
					row_n   = row_e + 7'd1;
					phase_n = (row_n >= 7'(ROWS)) ? PH_DONE : PH_MASK;
				end else begin
					mask_n      = data_byte;
					note_flag_n = 1'b0;
					vol_flag_n  = 1'b0;
					if (data_byte[5]) begin
						phase_n = PH_NOTE;
					end else if (data_byte[6]) begin
						phase_n = PH_VOL;
					end else if (data_byte[7]) begin
						phase_n = PH_FX;
					end else begin
						cell_done = 1'b1;
					end
				end
			end
			PH_NOTE: begin
				if (data_byte == NOTE_CUT) begin
					note_n      = NOTE_CUT;
					note_flag_n = 1'b1;
				end else if (data_byte <= NOTE_MAX_IN) begin
					note_n      = note_conv(data_byte);
					note_flag_n = 1'b1;
				end else begin
					note_flag_n = 1'b0;
				end
				phase_n = PH_INSTR;
			end
			PH_INSTR: begin
				instr_n = (data_byte <= INSTR_MAX) ? data_byte[6:0] : 7'd0;
				if (mask_q[6]) begin
					phase_n = PH_VOL;
				end else if (mask_q[7]) begin
					phase_n = PH_FX;
				end else begin
					cell_done = 1'b1;
				end
			end
			PH_VOL: begin
				if (data_byte != VOL_EMPTY) begin
					vol_n      = (data_byte <= VOL_MAX) ? data_byte[6:0] : VOL_MAX[6:0];
					vol_flag_n = 1'b1;
				end else begin
					vol_flag_n = 1'b0;
				end
				if (mask_q[7]) begin
					phase_n = PH_FX;
				end else begin
					cell_done = 1'b1;
				end
			end
			PH_FX: begin
				fx_n    = data_byte;
				phase_n = PH_PARAM;
			end
			PH_PARAM: begin
				cell_done = 1'b1;
				fx_wr     = 1'b1;
				case (fx_q)
					EFF_TEMPO: par = tempo_conv(data_byte);
					EFF_GVOL:  par = double_sat(data_byte);
					EFF_PAN: begin
						if (data_byte == PAN_SURROUND) begin
							eff = EFF_SPECIAL;
							par = SPC_SURROUND;
						end else begin
							par = double_sat(data_byte);
						end
					end
					EFF_VSLIDE: begin
						// fine slides (one nibble 0xF) and plain slides pass
						if (data_byte[3:0] != 4'h0 && data_byte[7:4] != 4'h0 &&
						    data_byte[3:0] != 4'hF && data_byte[7:4] != 4'hF) begin
							par = {4'h0, data_byte[3:0]};
						end
					end
					default: par = data_byte;
				endcase
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = phase_e;
			end
		endcase

		res.row = row_e[5:0];
		if (cell_done) begin
			has_res         = 1'b1;
			phase_n         = PH_MASK;
			res.channel     = mask_n[4:0];
			res.note_write  = mask_n[5] && note_flag_n;
			res.note        = (mask_n[5] && note_flag_n) ? note_n : 8'd0;
			res.instr_write = mask_n[5];
			res.instrument  = mask_n[5] ? instr_n : 7'd0;
			res.vol_write   = vol_flag_n;
			res.volume      = vol_flag_n ? vol_n : 7'd0;
			res.fx_write    = fx_wr;
			res.effect      = fx_wr ? eff : 8'd0;
			res.param       = fx_wr ? par : 8'd0;
		end else begin
			res.row_end     = has_res;
		end
	end

	// parse state and transfer valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MASK;
			row_q        <= '0;
			mask_q       <= '0;
			note_q       <= '0;
			note_flag_q  <= 1'b0;
			instr_q      <= '0;
			vol_q        <= '0;
			vol_flag_q   <= 1'b0;
			fx_q         <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				row_q       <= row_n;
				mask_q      <= mask_n;
				note_q      <= note_n;
				note_flag_q <= note_flag_n;
				instr_q     <= instr_n;
				vol_q       <= vol_n;
				vol_flag_q  <= vol_flag_n;
				fx_q        <= fx_n;
			end
			if (accept && has_res) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result_valid = out_valid_q;
	assign row          = out_q.row;
	assign channel      = out_q.channel;
	assign note_write   = out_q.note_write;
	assign note         = out_q.note;
	assign instr_write  = out_q.instr_write;
	assign instrument   = out_q.instrument;
	assign vol_write    = out_q.vol_write;
	assign volume       = out_q.volume;
	assign fx_write     = out_q.fx_write;
	assign effect       = out_q.effect;
	assign param        = out_q.param;
	assign row_end      = out_q.row_end;

	// skid entry only fills behind a stalled result
	`PPD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	// row end carries no cell writes
	`PPD_ASSERT_NOW(a_row_end_clean, out_valid_q && out_q.row_end,
		!out_q.note_write && !out_q.instr_write && !out_q.vol_write && !out_q.fx_write)
	// finished pattern stays finished until restarted
	`PPD_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE && !(accept && pattern_start),
		phase_q == PH_DONE)
	`PPD_ASSERT_NOW(a_vol_clamped, out_valid_q && out_q.vol_write, out_q.volume <= 7'd64)
	`PPD_ASSERT_NOW(a_instr_clamped, out_valid_q && out_q.instr_write,
		out_q.instrument <= 7'd99)

endmodule

### bench/packed_pattern_decoder_tb.sv
// ----------------------------------------------------------------------------
// Packed pattern decoder testbench
// Feeds packed pattern byte streams through the decoder and checks each cell
// write and row end against a cycle-free prediction of the decode rules.
// ----------------------------------------------------------------------------
// Stimulus opens with a short directed sequence (field extremes, several effect
// conversions, empty cells) and then runs random patterns: mostly well-formed
// rows of random entries, some full 64-row patterns with trailing bytes that
// must be dropped, entries cut short by a new pattern, and raw noise.
// Both sides idle at random; the receiver also stalls for a long stretch so
// the decoder backs up, and the sender sometimes waits for a full drain.
module packed_pattern_decoder_tb;
	import ppd_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RANDOM_BYTES = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 20;

	// mask byte data flags
	localparam logic [7:0] MASK_NI  = 8'h20;
	localparam logic [7:0] MASK_VOL = 8'h40;
	localparam logic [7:0] MASK_FX  = 8'h80;

	// decode position within the packed stream
	typedef enum logic [2:0] {
		WANT_MASK,
		WANT_NOTE,
		WANT_INSTR,
		WANT_VOL,
		WANT_FX,
		WANT_PARAM,
		ROWS_DONE
	} dec_step_e;

	// ------------------------------------------------------------------------
	// Cell tracker: follows the byte stream and queues the cells it implies.
	// ------------------------------------------------------------------------
	class cell_tracker;
		dec_step_e  step;
		logic [6:0] row_cnt;
		logic [7:0] mask_q;
		logic [7:0] note_q;
		logic       note_ok;
		logic [6:0] instr_q;
		logic [6:0] vol_q;
		logic       vol_ok;
		logic [7:0] fx_q;
		res_t       pending_cells[$];
		int         errors;
		int         taken;
		int         cells;
		int         row_ends;
		int         patterns;

		function new();
			step     = WANT_MASK;
			row_cnt  = '0;
			mask_q   = '0;
			note_q   = '0;
			note_ok  = 1'b0;
			instr_q  = '0;
			vol_q    = '0;
			vol_ok   = 1'b0;
			fx_q     = '0;
			errors   = 0;
			taken    = 0;
			cells    = 0;
			row_ends = 0;
			patterns = 0;
		endfunction

		function logic [7:0] sat_double(input logic [7:0] p);
			return (p < 8'd128) ? {p[6:0], 1'b0} : 8'hFF;
		endfunction

		// one accepted transfer on the byte side
		function void take_byte(input logic [7:0] b, input logic st);
			res_t       r;
			logic [7:0] eff, par, lo, hi;
			bit         emit, fx;
			emit = 0;
			fx   = 0;
			eff  = '0;
			par  = '0;
			if (st) begin
				step    = WANT_MASK;
				row_cnt = '0;
				patterns++;
			end
			if (step != ROWS_DONE)
				taken++;
			case (step)
				WANT_MASK: begin
					if (b == 8'h00) begin
						r         = '0;
						r.row     = row_cnt[5:0];
						r.row_end = 1'b1;
						pending_cells.push_back(r);
						row_ends++;
						row_cnt = row_cnt + 7'd1;
						step    = (row_cnt >= 7'(ROWS)) ? ROWS_DONE : WANT_MASK;
					end else begin
						mask_q  = b;
						note_ok = 1'b0;
						vol_ok  = 1'b0;
						if (b[5])
							step = WANT_NOTE;
						else if (b[6])
							step = WANT_VOL;
						else if (b[7])
							step = WANT_FX;
						else
							emit = 1;
					end
				end
				WANT_NOTE: begin
					if (b == NOTE_CUT) begin
						note_q  = NOTE_CUT;
						note_ok = 1'b1;
					end else if (b <= NOTE_MAX_IN) begin
						note_q  = 8'(12 + int'(b[7:4]) * 12 + int'(b[3:0]));
						note_ok = 1'b1;
					end else begin
						note_ok = 1'b0;
					end
					step = WANT_INSTR;
				end
				WANT_INSTR: begin
					instr_q = (b <= INSTR_MAX) ? b[6:0] : 7'd0;
					if (mask_q[6])
						step = WANT_VOL;
					else if (mask_q[7])
						step = WANT_FX;
					else
						emit = 1;
				end
				WANT_VOL: begin
					if (b != VOL_EMPTY) begin
						vol_q  = (b <= VOL_MAX) ? b[6:0] : VOL_MAX[6:0];
						vol_ok = 1'b1;
					end else begin
						vol_ok = 1'b0;
					end
					if (mask_q[7])
						step = WANT_FX;
					else
						emit = 1;
				end
				WANT_FX: begin
					fx_q = b;
					step = WANT_PARAM;
				end
				WANT_PARAM: begin
					eff = fx_q;
					par = b;
					lo  = b & 8'h0F;
					hi  = b & 8'hF0;
					if (eff == EFF_TEMPO) begin
						// hex-coded tempo read as decimal
						par = lo + (hi >> 1) + (hi >> 3);
					end else if (eff == EFF_GVOL) begin
						par = sat_double(b);
					end else if (eff == EFF_PAN) begin
						if (b == PAN_SURROUND) begin
							eff = EFF_SPECIAL;
							par = SPC_SURROUND;
						end else begin
							par = sat_double(b);
						end
					end else if (eff == EFF_VSLIDE && lo != 8'h00 && hi != 8'h00 &&
							lo != 8'h0F && hi != 8'hF0) begin
						// two-direction slide keeps the down part only
						par = lo;
					end
					fx   = 1;
					emit = 1;
				end
				default: ;
			endcase
			if (emit) begin
				r         = '0;
				r.row     = row_cnt[5:0];
				r.channel = mask_q[4:0];
				if (mask_q[5] && note_ok) begin
					r.note_write = 1'b1;
					r.note       = note_q;
				end
				if (mask_q[5]) begin
					r.instr_write = 1'b1;
					r.instrument  = instr_q;
				end
				if (vol_ok) begin
					r.vol_write = 1'b1;
					r.volume    = vol_q;
				end
				if (fx) begin
					r.fx_write = 1'b1;
					r.effect   = eff;
					r.param    = par;
				end
				pending_cells.push_back(r);
				cells++;
				step = WANT_MASK;
			end
		endfunction

		function void field_cmp(input string nm, input int e, input int a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
				errors++;
			end
		endfunction

		// one accepted transfer on the result side
		function void check_cell(input res_t got);
			res_t e;
			if (pending_cells.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, got %p",
					$time, got);
				errors++;
				return;
			end
			e = pending_cells.pop_front();
			field_cmp("row",         e.row,         got.row);
			field_cmp("channel",     e.channel,     got.channel);
			field_cmp("note_write",  e.note_write,  got.note_write);
			field_cmp("note",        e.note,        got.note);
			field_cmp("instr_write", e.instr_write, got.instr_write);
			field_cmp("instrument",  e.instrument,  got.instrument);
			field_cmp("vol_write",   e.vol_write,   got.vol_write);
			field_cmp("volume",      e.volume,      got.volume);
			field_cmp("fx_write",    e.fx_write,    got.fx_write);
			field_cmp("effect",      e.effect,      got.effect);
			field_cmp("param",       e.param,       got.param);
			field_cmp("row_end",     e.row_end,     got.row_end);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       data_valid;
	logic       data_ready;
	logic [7:0] data_byte;
	logic       pattern_start;
	logic       result_valid;
	logic       result_ready;
	logic [5:0] row;
	logic [4:0] channel;
	logic       note_write;
	logic [7:0] note;
	logic       instr_write;
	logic [6:0] instrument;
	logic       vol_write;
	logic [6:0] volume;
	logic       fx_write;
	logic [7:0] effect;
	logic [7:0] param;
	logic       row_end;

	cell_tracker sb;

	bit tx_idle;     // sender inserts random gaps
	bit start_pend;  // next byte carries pattern_start
	bit hold_req;    // ask the receiver for one long stall

	packed_pattern_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.pattern_start (pattern_start),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.row           (row),
		.channel       (channel),
		.note_write    (note_write),
		.note          (note),
		.instr_write   (instr_write),
		.instrument    (instrument),
		.vol_write     (vol_write),
		.volume        (volume),
		.fx_write      (fx_write),
		.effect        (effect),
		.param         (param),
		.row_end       (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the handshake hangs; far beyond the slowest good run.
	initial begin
		#(CLK_PERIOD * 400000);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte side. Tasks are entered and left at a falling edge; data_valid is
	// left high after a transfer and only dropped if the next byte idles, so
	// it never sees two updates in one step.
	// ------------------------------------------------------------------------
	task automatic put(input logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid    <= 1'b1;
		data_byte     <= b;
		pattern_start <= start_pend;
		do @(posedge clk); while (!data_ready);
		sb.take_byte(b, start_pend);
		start_pend = 1'b0;
		@(negedge clk);
	endtask

	// stop offering until every queued cell has come out
	task automatic drain_wait();
		data_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_cells.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_note();
		case ($urandom_range(0, 7))
			0:       return NOTE_CUT;
			1:       return 8'($urandom_range(128, 255));
			default: return 8'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [7:0] pick_vol();
		case ($urandom_range(0, 5))
			0:       return VOL_EMPTY;
			1:       return 8'($urandom_range(65, 254));
			default: return 8'($urandom_range(0, 64));
		endcase
	endfunction

	function automatic logic [7:0] pick_effect();
		case ($urandom_range(0, 5))
			0:       return EFF_TEMPO;
			1:       return EFF_VSLIDE;
			2:       return EFF_GVOL;
			3:       return EFF_PAN;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_param(input logic [7:0] eff);
		if (eff == EFF_PAN && $urandom_range(0, 2) == 0)
			return PAN_SURROUND;
		// slides with a 0 or F upper nibble
		if (eff == EFF_VSLIDE && $urandom_range(0, 1) == 0)
			return {($urandom_range(0, 1) ? 4'hF : 4'h0), 4'($urandom)};
		return 8'($urandom);
	endfunction

	// One entry: mask then the bytes its flags call for. A cut entry stops
	// early and the next byte starts a new pattern, dropping it.
	task automatic send_entry(input bit cut);
		logic [7:0] seq[$];
		logic [7:0] m, eff;
		int         keep;
		m = 8'($urandom);
		if (cut && m[7:5] == 3'b000)
			m[5 + $urandom_range(0, 2)] = 1'b1;
		if (m == 8'h00)
			m = 8'($urandom_range(1, 31));
		seq.push_back(m);
		if (m[5]) begin
			seq.push_back(pick_note());
			seq.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(100, 255)) :
				8'($urandom_range(0, 99)));
		end
		if (m[6])
			seq.push_back(pick_vol());
		if (m[7]) begin
			eff = pick_effect();
			seq.push_back(eff);
			seq.push_back(pick_param(eff));
		end
		keep = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
		for (int i = 0; i < keep; i++)
			put(seq[i]);
		if (cut)
			start_pend = 1'b1;
	endtask

	// rows of random entries; a full pattern is followed by bytes to drop
	task automatic send_pattern(input int nrows, input bit fresh);
		if (fresh)
			start_pend = 1'b1;
		for (int r = 0; r < nrows; r++) begin
			repeat ($urandom_range(0, 3)) send_entry(1'b0);
			put(8'h00);
		end
		if (nrows == ROWS)
			repeat ($urandom_range(1, 6)) put(8'($urandom));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			start_pend = ($urandom_range(0, 7) == 0);
			put(8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: draws a stall per result, serves one long hold on request.
	// ------------------------------------------------------------------------
	initial begin : result_side
		int   gap;
		bit   rx_idle;
		res_t got;
		rx_idle = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_idle = ~rx_idle;
			gap = rx_idle ? $urandom_range(0, 5) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap      = HOLD_CYCLES;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			got.row         = row;
			got.channel     = channel;
			got.note_write  = note_write;
			got.note        = note;
			got.instr_write = instr_write;
			got.instrument  = instrument;
			got.vol_write   = vol_write;
			got.volume      = volume;
			got.fx_write    = fx_write;
			got.effect      = effect;
			got.param       = param;
			got.row_end     = row_end;
			sb.check_cell(got);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : byte_side
		logic [7:0] directed[] = '{
			// mask with no data flags: empty cell
			8'h01,
			// everything on channel 31: lowest note, top instrument and volume,
			// tempo with both nibbles full
			MASK_NI | MASK_VOL | MASK_FX | 8'h1F, 8'h00, INSTR_MAX, VOL_MAX,
			EFF_TEMPO, 8'hFF,
			// note cut, instrument past range, empty volume, surround pan
			MASK_NI | MASK_VOL | MASK_FX, NOTE_CUT, 8'd100, VOL_EMPTY,
			EFF_PAN, PAN_SURROUND,
			// top note, instrument 255, volume just over the clamp
			MASK_NI | MASK_VOL | 8'h05, NOTE_MAX_IN, 8'hFF, 8'd65,
			// global volume doubling saturates
			MASK_FX | 8'h0A, EFF_GVOL, 8'h80,
			// note byte past range: no note write
			MASK_NI | 8'h10, 8'h80, 8'h00,
			// two-way volume slide
			MASK_FX | 8'h01, EFF_VSLIDE, 8'h53,
			// row end
			8'h00
		};
		int chunk;
		int goal;
		int pick;

		sb            = new();
		arst_n        = 1'b0;
		data_valid    = 1'b0;
		data_byte     = 8'h00;
		pattern_start = 1'b0;
		result_ready  = 1'b0;
		tx_idle       = 1'b1;
		start_pend    = 1'b0;
		hold_req      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		start_pend = 1'b1;
		foreach (directed[i])
			put(directed[i]);
		drain_wait();

		goal  = sb.taken + RANDOM_BYTES;
		chunk = 0;
		while (sb.taken < goal) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			// long receiver stall with the sender pushing at full rate
			if (chunk == 3 || chunk == 12) begin
				hold_req = 1'b1;
				tx_idle  = 1'b0;
			end
			if (chunk % 25 == 10)
				drain_wait();
			pick = $urandom_range(0, 19);
			if (chunk == 0 || pick == 4)
				send_pattern(ROWS, 1'b1);
			else if (pick < 2)
				send_noise();
			else if (pick < 4)
				send_entry(1'b1);
			else
				send_pattern($urandom_range(1, 6), $urandom_range(0, 3) != 0);
			chunk++;
		end
		data_valid <= 1'b0;

		while (sb.pending_cells.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d decoded bytes over %0d pattern starts", sb.taken,
			sb.patterns);
		$display("checked %0d cell writes and %0d row ends", sb.cells, sb.row_ends);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
